// File: sv/ontb_pkg.sv
`default_nettype none
// ============================================================================
// ontb_pkg
// Shared types, widths and codes of the outline node to segment converter.
// ============================================================================
package ontb_pkg;

    // Coordinate and matrix formats.
    localparam int COORD_WIDTH  = 24;
    localparam int MTX_WIDTH    = 32;
    localparam int MTX_FRAC     = 16;
    localparam int OFFSET_WIDTH = 24;

    // A product with its fraction bits dropped, and the sum of three terms.
    localparam int PROD_WIDTH = COORD_WIDTH + MTX_WIDTH - MTX_FRAC;
    localparam int SUM_WIDTH  = PROD_WIDTH + 2;

    // Stream payload widths.
    localparam int IN_DATA_WIDTH  = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int IN_USER_WIDTH  = 4;
    localparam int OUT_DATA_WIDTH = ((6 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_USER_WIDTH = 3;

    // Configuration port.
    localparam int CFG_ADDR_WIDTH = 5;
    localparam int CFG_DATA_WIDTH = 32;

    // Segment queue and flow control.
    localparam int MAX_SEGS       = 3;
    localparam int SEG_N_WIDTH    = $clog2(MAX_SEGS + 1);
    localparam int SEG_FIFO_DEPTH = 16;
    localparam int SEG_PTR_WIDTH  = $clog2(SEG_FIFO_DEPTH);
    localparam int SEG_CNT_WIDTH  = $clog2(SEG_FIFO_DEPTH + 1);
    localparam int INFLIGHT_MAX   = 3;
    localparam int INFLIGHT_WIDTH = $clog2(INFLIGHT_MAX + 1);

    typedef logic signed [COORD_WIDTH-1:0]  t_coord;
    typedef logic signed [MTX_WIDTH-1:0]    t_mtx;
    typedef logic signed [OFFSET_WIDTH-1:0] t_offset;

    typedef enum logic [1:0] {
        NODE_MOVE  = 2'd0,
        NODE_ON    = 2'd1,
        NODE_QUAD  = 2'd2,
        NODE_CUBIC = 2'd3
    } t_node_kind;

    typedef enum logic [2:0] {
        SEG_MOVE  = 3'd0,
        SEG_LINE  = 3'd1,
        SEG_QUAD  = 3'd2,
        SEG_CUBIC = 3'd3,
        SEG_CLOSE = 3'd4
    } t_seg_kind;

    typedef enum logic [2:0] {
        REG_SCALE_XX = 3'd0,
        REG_SHEAR_XY = 3'd1,
        REG_SHEAR_YX = 3'd2,
        REG_SCALE_YY = 3'd3,
        REG_OFFSET_X = 3'd4,
        REG_OFFSET_Y = 3'd5
    } t_reg_idx;

    typedef struct packed {
        t_node_kind node_kind;
        t_coord     coord_x;
        t_coord     coord_y;
        logic       first_node;
        logic       last_node;
        logic       contour_open;
    } t_node;

    typedef struct packed {
        t_mtx    scale_xx;
        t_mtx    shear_xy;
        t_mtx    shear_yx;
        t_mtx    scale_yy;
        t_offset offset_x;
        t_offset offset_y;
    } t_xform_cfg;

    typedef struct packed {
        t_seg_kind seg_kind;
        t_coord    ctrl1_x;
        t_coord    ctrl1_y;
        t_coord    ctrl2_x;
        t_coord    ctrl2_y;
        t_coord    end_x;
        t_coord    end_y;
        logic      last_of_run;
    } t_seg;

endpackage
`default_nettype wire

// File: sv/ontb_xform.sv
`default_nettype none
// ============================================================================
// ontb_xform
// Two-stage affine transform of a node point: products, then sum and clamp.
// ============================================================================
module ontb_xform (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  ontb_pkg::t_node        i_node,
    input  ontb_pkg::t_xform_cfg   i_cfg,
    output logic                   o_s1_valid,
    output logic                   o_valid,
    output ontb_pkg::t_node        o_node
);
    import ontb_pkg::*;

    localparam int FULL_WIDTH = COORD_WIDTH + MTX_WIDTH;

    logic signed [FULL_WIDTH-1:0] w_full_xx, w_full_yx, w_full_xy, w_full_yy;
    logic signed [PROD_WIDTH-1:0] r_p_xx, r_p_yx, r_p_xy, r_p_yy;
    logic signed [SUM_WIDTH-1:0]  w_sum_x, w_sum_y;
    logic                         r_v1, r_v2;
    t_node                        r_node1, r_node2, n_node2;

    // Clamp a wide sum into the coordinate range.
    function automatic t_coord sat_coord(input logic signed [SUM_WIDTH-1:0] v);
        logic [SUM_WIDTH-COORD_WIDTH:0] hi_bits;
        t_coord                         res;
        hi_bits = v[SUM_WIDTH-1:COORD_WIDTH-1];
        if ((&hi_bits) || !(|hi_bits)) begin
            res = v[COORD_WIDTH-1:0];
        end else if (v[SUM_WIDTH-1]) begin
            res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

    // Stage one: four signed products.
    assign w_full_xx = i_node.coord_x * i_cfg.scale_xx;
    assign w_full_yx = i_node.coord_y * i_cfg.shear_yx;
    assign w_full_xy = i_node.coord_x * i_cfg.shear_xy;
    assign w_full_yy = i_node.coord_y * i_cfg.scale_yy;

    // Dropping the fraction bits of a two's complement product rounds down.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_node1 <= i_node;
        r_p_xx  <= w_full_xx[FULL_WIDTH-1:MTX_FRAC];
        r_p_yx  <= w_full_yx[FULL_WIDTH-1:MTX_FRAC];
        r_p_xy  <= w_full_xy[FULL_WIDTH-1:MTX_FRAC];
        r_p_yy  <= w_full_yy[FULL_WIDTH-1:MTX_FRAC];
    end

    // Stage two: add the translation and clamp.
    assign w_sum_x = SUM_WIDTH'(r_p_xx) + SUM_WIDTH'(r_p_yx) + SUM_WIDTH'(i_cfg.offset_x);
    assign w_sum_y = SUM_WIDTH'(r_p_xy) + SUM_WIDTH'(r_p_yy) + SUM_WIDTH'(i_cfg.offset_y);

    always_comb begin
        n_node2         = r_node1;
        n_node2.coord_x = sat_coord(w_sum_x);
        n_node2.coord_y = sat_coord(w_sum_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_node2 <= n_node2;
    end

    assign o_s1_valid = r_v1;
    assign o_valid    = r_v2;
    assign o_node     = r_node2;

endmodule
`default_nettype wire

// File: sv/ontb_seg_fifo.sv
`default_nettype none
// ============================================================================
// ontb_seg_fifo
// Segment queue: up to three writes per cycle, one read per cycle on i_ready.
// ============================================================================
module ontb_seg_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [ontb_pkg::SEG_N_WIDTH-1:0]    i_wr_cnt,
    input  ontb_pkg::t_seg [ontb_pkg::MAX_SEGS-1:0] i_wr_seg,
    output logic                                o_valid,
    output ontb_pkg::t_seg                      o_seg,
    input  logic                                i_ready,
    output logic [ontb_pkg::SEG_CNT_WIDTH-1:0]  o_count
);
    import ontb_pkg::*;

    t_seg                     r_mem [SEG_FIFO_DEPTH];
    logic [SEG_PTR_WIDTH-1:0] r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [SEG_CNT_WIDTH-1:0] r_count, n_count;
    logic                     w_pop;

    assign o_valid = (r_count != '0);
    assign o_seg   = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = o_valid && i_ready;

    // Entries land in order behind the write pointer.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_SEGS; k++) begin
            if (k < int'(i_wr_cnt)) begin
                r_mem[r_wr_ptr + SEG_PTR_WIDTH'(k)] <= i_wr_seg[k];
            end
        end
    end

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr + SEG_PTR_WIDTH'(i_wr_cnt);
        n_rd_ptr = r_rd_ptr + SEG_PTR_WIDTH'(w_pop);
        n_count  = r_count + SEG_CNT_WIDTH'(i_wr_cnt) - SEG_CNT_WIDTH'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef SYNTHESIS
    // The fill count never passes the depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SEG_CNT_WIDTH'(SEG_FIFO_DEPTH))
        else $error("segment queue count out of range");

    // The upstream reservation keeps every write within the free space.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} + (SEG_CNT_WIDTH+1)'(i_wr_cnt))
            <= (SEG_CNT_WIDTH+1)'(SEG_FIFO_DEPTH))
        else $error("segment queue overflow");
`endif

endmodule
`default_nettype wire

// File: sv/outline_nodes_to_bezier_segments.sv
`default_nettype none
// ============================================================================
// outline_nodes_to_bezier_segments
// Turns a stream of glyph outline nodes into move, line, quadratic, cubic and
// close segments, with each point mapped through a configurable affine matrix.
// ============================================================================
//  Channel   Direction  Transfer carries
//  s_*       in         one outline node: kind, point, contour marks
//  m_*       out        one path segment: kind, two control points, end point
//  APB       in/out     matrix terms and translation, read back on prdata
//
//  A node is taken every cycle while o_s_tready is high; its first segment
//  is offered after the input register, product register, sum register and
//  queue write. Segments leave at one per cycle while i_m_tready is high,
//  through a 16-entry queue, so a node giving two or three segments hands
//  them out one at a time. o_s_tready drops while the queue cannot hold three
//  segments for every node in the pipeline plus the next one.
//  Reset is synchronous; it loads the identity matrix and clears control state.
// ============================================================================
module outline_nodes_to_bezier_segments (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Node input
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // coord_x, coord_y
    input  logic [ontb_pkg::IN_DATA_WIDTH-1:0]    i_s_tdata,
    // node_kind[1:0], first_node, contour_open
    input  logic [ontb_pkg::IN_USER_WIDTH-1:0]    i_s_tuser,
    // last_node
    input  logic                                  i_s_tlast,
    // Segment output
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
    output logic [ontb_pkg::OUT_DATA_WIDTH-1:0]   o_m_tdata,
    // seg_kind[2:0]
    output logic [ontb_pkg::OUT_USER_WIDTH-1:0]   o_m_tuser,
    // last_of_run
    output logic                                  o_m_tlast,
    // Configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ontb_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
    input  logic [ontb_pkg::CFG_DATA_WIDTH-1:0]   pwdata,
    output logic [ontb_pkg::CFG_DATA_WIDTH-1:0]   prdata,
    output logic                                  pready
);
    import ontb_pkg::*;

    localparam int RES_WIDTH = $clog2(SEG_FIFO_DEPTH + MAX_SEGS * (INFLIGHT_MAX + 1) + 1);
    localparam int SCALE_ONE = 1 << MTX_FRAC;

    t_xform_cfg                 r_cfg;
    t_reg_idx                   w_reg_idx;
    logic                       w_cfg_wr;

    logic                       w_in_xfer;
    logic                       r_in_valid;
    t_node                      r_in_node, w_in_node;

    logic                       xf_s1_valid, xf_valid;
    t_node                      xf_node;

    logic [INFLIGHT_WIDTH-1:0]  w_inflight;
    logic [RES_WIDTH-1:0]       w_need;
    logic [SEG_CNT_WIDTH-1:0]   w_q_count;

    t_coord                     r_start_x, r_start_y, n_start_x, n_start_y;
    t_coord                     r_pend1_x, r_pend1_y, n_pend1_x, n_pend1_y;
    t_coord                     r_pend2_x, r_pend2_y, n_pend2_x, n_pend2_y;
    logic [1:0]                 r_pend_cnt, n_pend_cnt;
    logic                       r_quad, n_quad;

    logic signed [COORD_WIDTH:0] w_mid_sum_x, w_mid_sum_y;
    t_seg                       w_seg_a, w_seg_b, w_seg_c;
    logic                       w_va, w_vb, w_vc;
    t_seg [MAX_SEGS-1:0]        w_slot;
    logic [SEG_N_WIDTH-1:0]     w_n, w_wr_cnt;
    t_seg                       w_out_seg;

    // Segment with only an end point.
    function automatic t_seg point_seg(input t_seg_kind kind, input t_coord ex,
                                       input t_coord ey);
        t_seg s;
        s          = '0;
        s.seg_kind = kind;
        s.end_x    = ex;
        s.end_y    = ey;
        return s;
    endfunction

    // Segment that uses up the pending control points, ending at (ex, ey).
    // With nothing pending it is a close segment.
    function automatic t_seg finish_seg(input logic [1:0] cnt, input logic quad,
                                        input t_coord p1x, input t_coord p1y,
                                        input t_coord p2x, input t_coord p2y,
                                        input t_coord ex, input t_coord ey);
        t_seg s;
        s          = '0;
        s.seg_kind = SEG_CLOSE;
        s.end_x    = ex;
        s.end_y    = ey;
        if (cnt == 2'd1) begin
            s.ctrl1_x = p1x;
            s.ctrl1_y = p1y;
            if (quad) begin
                s.seg_kind = SEG_QUAD;
            end else begin
                s.seg_kind = SEG_CUBIC;
                s.ctrl2_x  = ex;
                s.ctrl2_y  = ey;
            end
        end else if (cnt != 2'd0) begin
            s.seg_kind = SEG_CUBIC;
            s.ctrl1_x  = p1x;
            s.ctrl1_y  = p1y;
            s.ctrl2_x  = p2x;
            s.ctrl2_y  = p2y;
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = t_reg_idx'(paddr[CFG_ADDR_WIDTH-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_xx <= t_mtx'(SCALE_ONE);
            r_cfg.shear_xy <= '0;
            r_cfg.shear_yx <= '0;
            r_cfg.scale_yy <= t_mtx'(SCALE_ONE);
            r_cfg.offset_x <= '0;
            r_cfg.offset_y <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_SCALE_XX: r_cfg.scale_xx <= pwdata[MTX_WIDTH-1:0];
                REG_SHEAR_XY: r_cfg.shear_xy <= pwdata[MTX_WIDTH-1:0];
                REG_SHEAR_YX: r_cfg.shear_yx <= pwdata[MTX_WIDTH-1:0];
                REG_SCALE_YY: r_cfg.scale_yy <= pwdata[MTX_WIDTH-1:0];
                REG_OFFSET_X: r_cfg.offset_x <= pwdata[OFFSET_WIDTH-1:0];
                REG_OFFSET_Y: r_cfg.offset_y <= pwdata[OFFSET_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Read back, sign extended to the bus width.
    always_comb begin
        unique case (w_reg_idx)
            REG_SCALE_XX: prdata = CFG_DATA_WIDTH'(r_cfg.scale_xx);
            REG_SHEAR_XY: prdata = CFG_DATA_WIDTH'(r_cfg.shear_xy);
            REG_SHEAR_YX: prdata = CFG_DATA_WIDTH'(r_cfg.shear_yx);
            REG_SCALE_YY: prdata = CFG_DATA_WIDTH'(r_cfg.scale_yy);
            REG_OFFSET_X: prdata = CFG_DATA_WIDTH'(r_cfg.offset_x);
            REG_OFFSET_Y: prdata = CFG_DATA_WIDTH'(r_cfg.offset_y);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register and flow control
    // ------------------------------------------------------------------
    // Accept only while the queue can hold the worst case of every node in flight.
    assign w_inflight = INFLIGHT_WIDTH'(r_in_valid) + INFLIGHT_WIDTH'(xf_s1_valid)
                      + INFLIGHT_WIDTH'(xf_valid);
    assign w_need     = RES_WIDTH'(w_q_count)
                      + RES_WIDTH'(MAX_SEGS) * (RES_WIDTH'(w_inflight) + RES_WIDTH'(1));
    assign o_s_tready = (w_need <= RES_WIDTH'(SEG_FIFO_DEPTH));
    assign w_in_xfer  = i_s_tvalid && o_s_tready;

    always_comb begin
        w_in_node.node_kind    = t_node_kind'(i_s_tuser[1:0]);
        w_in_node.coord_x      = i_s_tdata[COORD_WIDTH-1:0];
        w_in_node.coord_y      = i_s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
        w_in_node.first_node   = i_s_tuser[2];
        w_in_node.contour_open = i_s_tuser[3];
        w_in_node.last_node    = i_s_tlast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_xfer;
        end
        if (w_in_xfer) begin
            r_in_node <= w_in_node;
        end
    end

    // ------------------------------------------------------------------
    // Point transform
    // ------------------------------------------------------------------
    ontb_xform u_xform (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_in_valid),
        .i_node     (r_in_node),
        .i_cfg      (r_cfg),
        .o_s1_valid (xf_s1_valid),
        .o_valid    (xf_valid),
        .o_node     (xf_node)
    );

    // ------------------------------------------------------------------
    // Segment generation and contour state
    // ------------------------------------------------------------------
    // Implied on-curve midpoint between the pending point and this one, rounded down.
    assign w_mid_sum_x = {r_pend1_x[COORD_WIDTH-1], r_pend1_x}
                       + {xf_node.coord_x[COORD_WIDTH-1], xf_node.coord_x};
    assign w_mid_sum_y = {r_pend1_y[COORD_WIDTH-1], r_pend1_y}
                       + {xf_node.coord_y[COORD_WIDTH-1], xf_node.coord_y};

    // Segment a flushes before a move, b is the node's own, c closes a contour.
    always_comb begin
        w_seg_a    = '0;
        w_seg_b    = '0;
        w_va       = 1'b0;
        w_vb       = 1'b0;
        n_start_x  = r_start_x;
        n_start_y  = r_start_y;
        n_pend1_x  = r_pend1_x;
        n_pend1_y  = r_pend1_y;
        n_pend2_x  = r_pend2_x;
        n_pend2_y  = r_pend2_y;
        n_pend_cnt = r_pend_cnt;
        n_quad     = r_quad;

        if (xf_node.first_node) begin
            w_vb       = 1'b1;
            w_seg_b    = point_seg(SEG_MOVE, xf_node.coord_x, xf_node.coord_y);
            n_start_x  = xf_node.coord_x;
            n_start_y  = xf_node.coord_y;
            n_pend_cnt = 2'd0;
            n_quad     = 1'b0;
        end else begin
            unique case (xf_node.node_kind)
                NODE_MOVE: begin
                    w_va       = !xf_node.contour_open && (r_pend_cnt != 2'd0);
                    w_seg_a    = finish_seg(r_pend_cnt, r_quad, r_pend1_x, r_pend1_y,
                                            r_pend2_x, r_pend2_y, r_start_x, r_start_y);
                    w_vb       = 1'b1;
                    w_seg_b    = point_seg(SEG_MOVE, xf_node.coord_x, xf_node.coord_y);
                    n_pend_cnt = 2'd0;
                    n_quad     = 1'b0;
                end
                NODE_ON: begin
                    w_vb = 1'b1;
                    if (r_pend_cnt == 2'd0) begin
                        w_seg_b = point_seg(SEG_LINE, xf_node.coord_x, xf_node.coord_y);
                    end else begin
                        w_seg_b = finish_seg(r_pend_cnt, r_quad, r_pend1_x, r_pend1_y,
                                             r_pend2_x, r_pend2_y,
                                             xf_node.coord_x, xf_node.coord_y);
                    end
                    n_pend_cnt = 2'd0;
                    n_quad     = 1'b0;
                end
                NODE_QUAD: begin
                    w_vb            = r_quad;
                    w_seg_b         = point_seg(SEG_QUAD, w_mid_sum_x[COORD_WIDTH:1],
                                                w_mid_sum_y[COORD_WIDTH:1]);
                    w_seg_b.ctrl1_x = r_pend1_x;
                    w_seg_b.ctrl1_y = r_pend1_y;
                    n_pend1_x       = xf_node.coord_x;
                    n_pend1_y       = xf_node.coord_y;
                    n_pend_cnt      = 2'd1;
                    n_quad          = 1'b1;
                end
                NODE_CUBIC: begin
                    if (r_pend_cnt == 2'd0) begin
                        n_pend1_x  = xf_node.coord_x;
                        n_pend1_y  = xf_node.coord_y;
                        n_pend_cnt = 2'd1;
                    end else begin
                        n_pend2_x  = xf_node.coord_x;
                        n_pend2_y  = xf_node.coord_y;
                        n_pend_cnt = 2'd2;
                    end
                end
            endcase
        end

        // A closed contour ends on the state this node leaves behind.
        w_vc    = xf_node.last_node && !xf_node.contour_open;
        w_seg_c = finish_seg(n_pend_cnt, n_quad, n_pend1_x, n_pend1_y,
                             n_pend2_x, n_pend2_y, n_start_x, n_start_y);
        if (xf_node.last_node) begin
            n_pend_cnt = 2'd0;
            n_quad     = 1'b0;
        end
    end

    // Pack the valid segments into consecutive slots and mark the last one.
    always_comb begin
        w_n       = SEG_N_WIDTH'(w_va) + SEG_N_WIDTH'(w_vb) + SEG_N_WIDTH'(w_vc);
        w_slot[0] = w_va ? w_seg_a : (w_vb ? w_seg_b : w_seg_c);
        w_slot[1] = (w_va && w_vb) ? w_seg_b : w_seg_c;
        w_slot[2] = w_seg_c;
        for (int k = 0; k < MAX_SEGS; k++) begin
            w_slot[k].last_of_run = (SEG_N_WIDTH'(k + 1) == w_n);
        end
        w_wr_cnt  = xf_valid ? w_n : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_pend1_x  <= '0;
            r_pend1_y  <= '0;
            r_pend2_x  <= '0;
            r_pend2_y  <= '0;
            r_pend_cnt <= 2'd0;
            r_quad     <= 1'b0;
        end else if (xf_valid) begin
            r_start_x  <= n_start_x;
            r_start_y  <= n_start_y;
            r_pend1_x  <= n_pend1_x;
            r_pend1_y  <= n_pend1_y;
            r_pend2_x  <= n_pend2_x;
            r_pend2_y  <= n_pend2_y;
            r_pend_cnt <= n_pend_cnt;
            r_quad     <= n_quad;
        end
    end

    // ------------------------------------------------------------------
    // Segment queue and output
    // ------------------------------------------------------------------
    ontb_seg_fifo u_seg_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_cnt (w_wr_cnt),
        .i_wr_seg (w_slot),
        .o_valid  (o_m_tvalid),
        .o_seg    (w_out_seg),
        .i_ready  (i_m_tready),
        .o_count  (w_q_count)
    );

    assign o_m_tdata = OUT_DATA_WIDTH'({w_out_seg.end_y, w_out_seg.end_x,
                                        w_out_seg.ctrl2_y, w_out_seg.ctrl2_x,
                                        w_out_seg.ctrl1_y, w_out_seg.ctrl1_x});
    assign o_m_tuser = w_out_seg.seg_kind;
    assign o_m_tlast = w_out_seg.last_of_run;

`ifndef SYNTHESIS
    // At most two control points are ever pending.
    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt != 2'd3)
        else $error("pending control count out of range");

    // Quadratic mode only stands with a pending point.
    a_quad_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_quad |-> (r_pend_cnt != 2'd0))
        else $error("quadratic mode without a pending point");

    // The last node of a closed contour always yields at least one segment.
    a_close_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xf_valid && xf_node.last_node && !xf_node.contour_open) |-> (w_wr_cnt != '0))
        else $error("closed contour ended without a segment");
`endif

endmodule
`default_nettype wire
